// ===== design/tch_pkg.sv =====
`timescale 1ns / 1ps

package tch_pkg;

  localparam int STEP_MAX = 24;

  localparam logic [31:0] ATAN_BAM [STEP_MAX] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
    32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
    32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
    32'd166886,    32'd83443,     32'd41721,     32'd20860,
    32'd10430,     32'd5215,      32'd2607,      32'd1303,
    32'd651,       32'd325,       32'd162,       32'd81
  };

  localparam logic [31:0] INV_GAIN_Q30 = 32'd652032874;
  localparam longint      HALF_TURN    = 64'sd2147483648;
  localparam longint      QUARTER_TURN = 64'sd1073741824;

  localparam int DEG_FULL = 36000;
  localparam int DEG_HALF = 18000;

  // floor(2^48 / 36000)
  localparam logic [32:0] BAM_RECIP = 33'd7818749353;

  typedef struct packed {
    logic              sv;
    logic signed [15:0] fz;
    logic signed [15:0] fy;
    logic signed [15:0] fx;
  } rot_sb_t;

  typedef struct packed {
    logic zero;
    logic sv;
  } vec_sb_t;

endpackage

// ===== design/tilt_compensated_heading_unit.sv =====
// Throughput: one sample per cycle; every stage holds its own valid bit and
// advances whenever the stage after it is free or moving.
// Reset: synchronous, active low; clears the valid bits only, datapath
// registers are not reset and no clearing pass is needed.
`timescale 1ns / 1ps

module tilt_compensated_heading_unit #(
  parameter int CORDIC_STEPS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // field_x, field_y, field_z, roll_angle, pitch_angle
  input  logic [79:0] in_tdata,
  // sample_valid
  input  logic        in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // heading
  output logic [15:0] out_tdata
);
  import tch_pkg::*;

  localparam int NSTEP  = (CORDIC_STEPS < STEP_MAX) ? CORDIC_STEPS : STEP_MAX;
  localparam int W_ROT  = 34;
  localparam int W_VEC  = 50;
  localparam int ZW     = 34;
  localparam int RSBW   = $bits(rot_sb_t);
  localparam int VSBW   = $bits(vec_sb_t);

  // angle conversion stages
  logic [3:0] a_v_r;
  logic [3:0] a_vin;
  logic [4:0] a_rdy;
  rot_sb_t    a_sb_r [4];
  logic [15:0] a0_ang_r  [2];
  logic [48:0] a1_prod_r [2];
  logic [32:0] a2_q_r    [2];
  logic [17:0] a2_m_r    [2];
  logic [31:0] a3_bam_r  [2];
  logic [15:0] a0_ang_nxt [2];
  logic [32:0] a2_q_nxt   [2];
  logic [31:0] a3_bam_nxt [2];

  logic                       rot_in_ready;
  logic [1:0][W_ROT-1:0]      rot_x_in;
  logic [1:0][W_ROT-1:0]      rot_y_in;
  logic [1:0][ZW-1:0]         rot_z_in;
  logic                       rot_out_valid;
  logic [1:0][W_ROT-1:0]      rot_x_out;
  logic [1:0][W_ROT-1:0]      rot_y_out;
  logic [1:0][ZW-1:0]         rot_z_out;
  logic [RSBW-1:0]            rot_sb_out;

  // horizontal projection stages
  logic [3:0] b_v_r;
  logic [3:0] b_vin;
  logic [4:0] b_rdy;
  rot_sb_t    b_sb_r [4];
  logic signed [63:0] b0_srsp_r, b0_srcp_r;
  logic signed [31:0] b0_cr_r, b0_cp_r, b0_sp_r;
  logic signed [31:0] b1_srsp_r, b1_srcp_r, b1_cr_r, b1_cp_r, b1_sp_r;
  logic signed [47:0] b2_xc_r, b2_zs_r, b2_xss_r, b2_yc_r, b2_zsc_r;
  logic signed [W_VEC-1:0] b3_xh_r, b3_yh_r;
  logic signed [63:0] b1_srsp_nxt, b1_srcp_nxt;

  logic                       vec_in_ready;
  vec_sb_t                    vec_sb_in;
  logic                       vec_out_valid;
  logic [0:0][W_VEC-1:0]      vec_x_out;
  logic [0:0][W_VEC-1:0]      vec_y_out;
  logic [0:0][ZW-1:0]         vec_z_out;
  logic [VSBW-1:0]            vec_sb_out;

  // heading scaling stages
  logic [1:0] c_v_r;
  logic [1:0] c_vin;
  logic [2:0] c_rdy;
  vec_sb_t     c0_sb_r;
  logic [47:0] c0_prod_r;
  logic [15:0] c1_head_r;
  logic [15:0] c1_head_nxt;

  assign a_vin    = {a_v_r[2:0], in_tvalid};
  assign a_rdy[4] = rot_in_ready;
  assign in_tready = a_rdy[0];

  for (genvar k = 0; k < 4; k++) begin : g_a_rdy
    assign a_rdy[k] = !a_v_r[k] || a_rdy[k+1];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r <= '0;
    end else begin
      for (int k = 0; k < 4; k++) begin
        if (a_rdy[k]) begin
          a_v_r[k] <= a_vin[k];
        end
      end
    end
  end

  // reduce into 0 .. 35999, then round(a * 2^32 / 36000) by reciprocal and one correction
  always_comb begin
    logic signed [16:0] raw;
    logic [48:0]        rnd;
    logic signed [17:0] rem;
    for (int l = 0; l < 2; l++) begin
      raw = {in_tdata[48 + 16*l + 15], in_tdata[48 + 16*l +: 16]};
      a0_ang_nxt[l] = raw[16] ? 16'(raw + 17'(DEG_FULL)) : 16'(raw);
      rnd = a1_prod_r[l] + 49'h8000;
      a2_q_nxt[l] = rnd[48:16];
      rem = $signed(18'(DEG_HALF) - a2_m_r[l]);
      if (rem[17]) begin
        a3_bam_nxt[l] = 32'(a2_q_r[l] - 33'd1);
      end else if (rem >= $signed(18'(DEG_FULL))) begin
        a3_bam_nxt[l] = 32'(a2_q_r[l] + 33'd1);
      end else begin
        a3_bam_nxt[l] = a2_q_r[l][31:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (a_rdy[0]) begin
      a0_ang_r     <= a0_ang_nxt;
      a_sb_r[0].fx <= $signed(in_tdata[15:0]);
      a_sb_r[0].fy <= $signed(in_tdata[31:16]);
      a_sb_r[0].fz <= $signed(in_tdata[47:32]);
      a_sb_r[0].sv <= in_tuser;
    end
    if (a_rdy[1]) begin
      for (int l = 0; l < 2; l++) begin
        a1_prod_r[l] <= 49'(a0_ang_r[l]) * 49'(BAM_RECIP);
      end
      a_sb_r[1] <= a_sb_r[0];
    end
    if (a_rdy[2]) begin
      for (int l = 0; l < 2; l++) begin
        a2_m_r[l] <= a2_q_nxt[l][17:0] * 18'(DEG_FULL);
      end
      a2_q_r    <= a2_q_nxt;
      a_sb_r[2] <= a_sb_r[1];
    end
    if (a_rdy[3]) begin
      a3_bam_r  <= a3_bam_nxt;
      a_sb_r[3] <= a_sb_r[2];
    end
  end

  // lane 0 roll, lane 1 pitch
  always_comb begin
    for (int l = 0; l < 2; l++) begin
      rot_x_in[l] = W_ROT'(INV_GAIN_Q30);
      rot_y_in[l] = '0;
      rot_z_in[l] = ZW'($signed(a3_bam_r[l]));
    end
  end

  tch_cordic #(
    .LANES     (2),
    .W         (W_ROT),
    .ZW        (ZW),
    .VECTORING (1'b0),
    .STEPS     (NSTEP),
    .SBW       (RSBW)
  ) u_rot (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (a_v_r[3]),
    .in_ready  (rot_in_ready),
    .in_x      (rot_x_in),
    .in_y      (rot_y_in),
    .in_z      (rot_z_in),
    .in_sb     (a_sb_r[3]),
    .out_valid (rot_out_valid),
    .out_ready (b_rdy[0]),
    .out_x     (rot_x_out),
    .out_y     (rot_y_out),
    .out_z     (rot_z_out),
    .out_sb    (rot_sb_out)
  );

  assign b_vin    = {b_v_r[2:0], rot_out_valid};
  assign b_rdy[4] = vec_in_ready;

  for (genvar k = 0; k < 4; k++) begin : g_b_rdy
    assign b_rdy[k] = !b_v_r[k] || b_rdy[k+1];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_v_r <= '0;
    end else begin
      for (int k = 0; k < 4; k++) begin
        if (b_rdy[k]) begin
          b_v_r[k] <= b_vin[k];
        end
      end
    end
  end

  assign b1_srsp_nxt = b0_srsp_r + 64'sd536870912;
  assign b1_srcp_nxt = b0_srcp_r + 64'sd536870912;

  always_ff @(posedge clk) begin
    if (b_rdy[0]) begin
      b0_srsp_r <= 64'($signed(rot_y_out[0][31:0])) * 64'($signed(rot_y_out[1][31:0]));
      b0_srcp_r <= 64'($signed(rot_y_out[0][31:0])) * 64'($signed(rot_x_out[1][31:0]));
      b0_cr_r   <= $signed(rot_x_out[0][31:0]);
      b0_cp_r   <= $signed(rot_x_out[1][31:0]);
      b0_sp_r   <= $signed(rot_y_out[1][31:0]);
      b_sb_r[0] <= rot_sb_t'(rot_sb_out);
    end
    if (b_rdy[1]) begin
      b1_srsp_r <= $signed(b1_srsp_nxt[61:30]);
      b1_srcp_r <= $signed(b1_srcp_nxt[61:30]);
      b1_cr_r   <= b0_cr_r;
      b1_cp_r   <= b0_cp_r;
      b1_sp_r   <= b0_sp_r;
      b_sb_r[1] <= b_sb_r[0];
    end
    if (b_rdy[2]) begin
      b2_xc_r   <= 48'(b_sb_r[1].fx) * 48'(b1_cp_r);
      b2_zs_r   <= 48'(b_sb_r[1].fz) * 48'(b1_sp_r);
      b2_xss_r  <= 48'(b_sb_r[1].fx) * 48'(b1_srsp_r);
      b2_yc_r   <= 48'(b_sb_r[1].fy) * 48'(b1_cr_r);
      b2_zsc_r  <= 48'(b_sb_r[1].fz) * 48'(b1_srcp_r);
      b_sb_r[2] <= b_sb_r[1];
    end
    if (b_rdy[3]) begin
      b3_xh_r   <= W_VEC'(b2_xc_r) + W_VEC'(b2_zs_r);
      b3_yh_r   <= W_VEC'(b2_xss_r) + W_VEC'(b2_yc_r) - W_VEC'(b2_zsc_r);
      b_sb_r[3] <= b_sb_r[2];
    end
  end

  assign vec_sb_in.zero = (b3_xh_r == '0) && (b3_yh_r == '0);
  assign vec_sb_in.sv   = b_sb_r[3].sv;

  tch_cordic #(
    .LANES     (1),
    .W         (W_VEC),
    .ZW        (ZW),
    .VECTORING (1'b1),
    .STEPS     (NSTEP),
    .SBW       (VSBW)
  ) u_vec (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (b_v_r[3]),
    .in_ready  (vec_in_ready),
    .in_x      (b3_xh_r),
    .in_y      (b3_yh_r),
    .in_z      ('0),
    .in_sb     (vec_sb_in),
    .out_valid (vec_out_valid),
    .out_ready (c_rdy[0]),
    .out_x     (vec_x_out),
    .out_y     (vec_y_out),
    .out_z     (vec_z_out),
    .out_sb    (vec_sb_out)
  );

  assign c_vin    = {c_v_r[0], vec_out_valid};
  assign c_rdy[2] = out_tready;

  for (genvar k = 0; k < 2; k++) begin : g_c_rdy
    assign c_rdy[k] = !c_v_r[k] || c_rdy[k+1];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_v_r <= '0;
    end else begin
      for (int k = 0; k < 2; k++) begin
        if (c_rdy[k]) begin
          c_v_r[k] <= c_vin[k];
        end
      end
    end
  end

  // wrap a full turn to zero, give zero for invalid and zero-field samples
  always_comb begin
    c1_head_nxt = c0_prod_r[47:32];
    if (!c0_sb_r.sv || c0_sb_r.zero || (c0_prod_r[47:32] >= 16'(DEG_FULL))) begin
      c1_head_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (c_rdy[0]) begin
      c0_prod_r <= 48'(vec_z_out[0][31:0]) * 48'(DEG_FULL) + 48'h8000_0000;
      c0_sb_r   <= vec_sb_t'(vec_sb_out);
    end
    if (c_rdy[1]) begin
      c1_head_r <= c1_head_nxt;
    end
  end

  assign out_tvalid = c_v_r[1];
  assign out_tdata  = c1_head_r;

`ifndef SYNTHESIS
  a_head_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata < 16'(DEG_FULL)))
    else $error("heading out of range");

  a_rot_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (rot_out_valid && !b_rdy[0]) |=> (rot_out_valid && $stable(rot_sb_out)))
    else $error("rotation result dropped while stalled");

  a_vec_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (vec_out_valid && !c_rdy[0]) |=> (vec_out_valid && $stable(vec_z_out)))
    else $error("vectoring result dropped while stalled");
`endif

endmodule

// ===== design/tch_cordic.sv =====
`timescale 1ns / 1ps

module tch_cordic #(
  parameter int LANES     = 1,
  parameter int W         = 34,
  parameter int ZW        = 34,
  parameter bit VECTORING = 1'b0,
  parameter int STEPS     = 16,
  parameter int SBW       = 1
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [LANES-1:0][W-1:0]    in_x,
  input  logic [LANES-1:0][W-1:0]    in_y,
  input  logic [LANES-1:0][ZW-1:0]   in_z,
  input  logic [SBW-1:0]             in_sb,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [LANES-1:0][W-1:0]    out_x,
  output logic [LANES-1:0][W-1:0]    out_y,
  output logic [LANES-1:0][ZW-1:0]   out_z,
  output logic [SBW-1:0]             out_sb
);
  import tch_pkg::*;

  localparam int NS = STEPS + 2;
  localparam logic signed [ZW-1:0] HALF_Z = ZW'(HALF_TURN);
  localparam logic signed [ZW-1:0] QTR_Z  = ZW'(QUARTER_TURN);

  logic [NS-1:0] v_r;
  logic [NS-1:0] v_in;
  logic [NS:0]   rdy;

  logic signed [W-1:0]  x_r [NS][LANES];
  logic signed [W-1:0]  y_r [NS][LANES];
  logic signed [ZW-1:0] z_r [NS][LANES];
  logic [LANES-1:0]     flip_r [STEPS+1];
  logic [SBW-1:0]       sb_r [NS];

  logic signed [W-1:0]  x0_nxt [LANES];
  logic signed [W-1:0]  y0_nxt [LANES];
  logic signed [ZW-1:0] z0_nxt [LANES];
  logic [LANES-1:0]     flip0_nxt;

  assign v_in     = {v_r[NS-2:0], in_valid};
  assign rdy[NS]  = out_ready;
  assign in_ready = rdy[0];

  for (genvar k = 0; k < NS; k++) begin : g_rdy
    assign rdy[k] = !v_r[k] || rdy[k+1];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      for (int k = 0; k < NS; k++) begin
        if (rdy[k]) begin
          v_r[k] <= v_in[k];
        end
      end
    end
  end

  // fold into the convergence range
  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      x0_nxt[l]    = $signed(in_x[l]);
      y0_nxt[l]    = $signed(in_y[l]);
      z0_nxt[l]    = $signed(in_z[l]);
      flip0_nxt[l] = 1'b0;
      if (VECTORING) begin
        if (in_x[l][W-1]) begin
          x0_nxt[l] = -$signed(in_x[l]);
          y0_nxt[l] = -$signed(in_y[l]);
          z0_nxt[l] = $signed(in_z[l]) + HALF_Z;
        end
      end else begin
        if ($signed(in_z[l]) > QTR_Z) begin
          z0_nxt[l]    = $signed(in_z[l]) - HALF_Z;
          flip0_nxt[l] = 1'b1;
        end else if ($signed(in_z[l]) < -QTR_Z) begin
          z0_nxt[l]    = $signed(in_z[l]) + HALF_Z;
          flip0_nxt[l] = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      x_r[0]    <= x0_nxt;
      y_r[0]    <= y0_nxt;
      z_r[0]    <= z0_nxt;
      flip_r[0] <= flip0_nxt;
      sb_r[0]   <= in_sb;
    end
  end

  for (genvar k = 1; k <= STEPS; k++) begin : g_step
    localparam logic signed [ZW-1:0] ATZ = ZW'(ATAN_BAM[k-1]);
    logic signed [W-1:0]  x_nxt [LANES];
    logic signed [W-1:0]  y_nxt [LANES];
    logic signed [ZW-1:0] z_nxt [LANES];

    always_comb begin
      for (int l = 0; l < LANES; l++) begin
        if (VECTORING ? y_r[k-1][l][W-1] : !z_r[k-1][l][ZW-1]) begin
          x_nxt[l] = x_r[k-1][l] - (y_r[k-1][l] >>> (k-1));
          y_nxt[l] = y_r[k-1][l] + (x_r[k-1][l] >>> (k-1));
          z_nxt[l] = z_r[k-1][l] - ATZ;
        end else begin
          x_nxt[l] = x_r[k-1][l] + (y_r[k-1][l] >>> (k-1));
          y_nxt[l] = y_r[k-1][l] - (x_r[k-1][l] >>> (k-1));
          z_nxt[l] = z_r[k-1][l] + ATZ;
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rdy[k]) begin
        x_r[k]    <= x_nxt;
        y_r[k]    <= y_nxt;
        z_r[k]    <= z_nxt;
        flip_r[k] <= flip_r[k-1];
        sb_r[k]   <= sb_r[k-1];
      end
    end
  end

  // undo the half-turn fold
  logic signed [W-1:0] xp_nxt [LANES];
  logic signed [W-1:0] yp_nxt [LANES];

  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      xp_nxt[l] = flip_r[STEPS][l] ? -x_r[STEPS][l] : x_r[STEPS][l];
      yp_nxt[l] = flip_r[STEPS][l] ? -y_r[STEPS][l] : y_r[STEPS][l];
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[NS-1]) begin
      x_r[NS-1]  <= xp_nxt;
      y_r[NS-1]  <= yp_nxt;
      z_r[NS-1]  <= z_r[STEPS];
      sb_r[NS-1] <= sb_r[STEPS];
    end
  end

  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      out_x[l] = x_r[NS-1][l];
      out_y[l] = y_r[NS-1][l];
      out_z[l] = z_r[NS-1][l];
    end
  end

  assign out_valid = v_r[NS-1];
  assign out_sb    = sb_r[NS-1];

endmodule

// ===== tb/sv/heading_checker.sv =====
`timescale 1ns / 1ps

module heading_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [79:0] in_tdata,
  input  logic        in_tuser,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [15:0] out_tdata,
  output int          fail_count,
  output int          headings_seen,
  output int          pending_count
);
  import tch_pkg::*;

  localparam int STEPS = 16;

  logic [15:0] heading_queue[$];

  function automatic longint floor_shift(longint v, int n);
    return v >>> n;
  endfunction

  function automatic logic [31:0] angle_to_bam(logic signed [15:0] raw);
    longint r;
    logic [63:0] b;
    r = longint'(raw) % DEG_FULL;
    if (r < 0) r += DEG_FULL;
    b = (64'(r) * 64'd4294967296 + 64'd18000) / 64'd36000;
    return b[31:0];
  endfunction

  function automatic void rotate_sin_cos(input logic [31:0] bam, output longint c,
                                         output longint s);
    longint z, x, y, nx;
    bit flip;
    z = bam[31] ? longint'(bam) - 64'sd4294967296 : longint'(bam);
    x = longint'(INV_GAIN_Q30);
    y = 0;
    flip = 0;
    if (z > QUARTER_TURN) begin
      z -= HALF_TURN; flip = 1;
    end else if (z < -QUARTER_TURN) begin
      z += HALF_TURN; flip = 1;
    end
    for (int i = 0; i < STEPS; i++) begin
      if (z >= 0) begin
        nx = x - floor_shift(y, i); y = y + floor_shift(x, i); z -= longint'(ATAN_BAM[i]);
      end else begin
        nx = x + floor_shift(y, i); y = y - floor_shift(x, i); z += longint'(ATAN_BAM[i]);
      end
      x = nx;
    end
    c = flip ? -x : x;
    s = flip ? -y : y;
  endfunction

  function automatic logic [31:0] vector_angle(longint y, longint x);
    longint z, nx;
    z = 0;
    if (x < 0) begin
      x = -x; y = -y; z = HALF_TURN;
    end
    for (int i = 0; i < STEPS; i++) begin
      if (y >= 0) begin
        nx = x + floor_shift(y, i); y = y - floor_shift(x, i); z += longint'(ATAN_BAM[i]);
      end else begin
        nx = x - floor_shift(y, i); y = y + floor_shift(x, i); z -= longint'(ATAN_BAM[i]);
      end
      x = nx;
    end
    return z[31:0];
  endfunction

  function automatic logic [15:0] predict_heading(logic [79:0] d, logic ok);
    longint fx, fy, fz, cr, sr, cp, sp, srsp, srcp, xh, yh;
    logic [63:0] h;
    if (!ok) return 16'd0;
    fx = longint'($signed(d[15:0]));
    fy = longint'($signed(d[31:16]));
    fz = longint'($signed(d[47:32]));
    rotate_sin_cos(angle_to_bam(d[63:48]), cr, sr);
    rotate_sin_cos(angle_to_bam(d[79:64]), cp, sp);
    srsp = (sr * sp + (64'sd1 <<< 29)) >>> 30;
    srcp = (sr * cp + (64'sd1 <<< 29)) >>> 30;
    xh = fx * cp + fz * sp;
    yh = fx * srsp + fy * cr - fz * srcp;
    if (xh == 0 && yh == 0) return 16'd0;
    h = (64'(vector_angle(yh, xh)) * 64'd36000 + 64'd2147483648) >> 32;
    if (h >= 64'd36000) h = 0;
    return h[15:0];
  endfunction

  assign pending_count = heading_queue.size();

  initial begin
    fail_count = 0;
    headings_seen = 0;
  end

  always @(posedge clk) begin
    logic [15:0] want;
    if (rst_n) begin
      if (in_tvalid && in_tready) heading_queue.push_back(predict_heading(in_tdata, in_tuser));
      if (out_tvalid && out_tready) begin
        headings_seen++;
        if (heading_queue.size() == 0) begin
          fail_count++;
          if (fail_count <= 10) $display("unexpected heading %0d", out_tdata);
        end else begin
          want = heading_queue.pop_front();
          if (want !== out_tdata) begin
            fail_count++;
            if (fail_count <= 10)
              $display("heading mismatch #%0d: expected %0d got %0d", headings_seen, want,
                       out_tdata);
          end
        end
      end
    end
  end
endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
  localparam int RANDOM_ITEMS = 550;
  localparam int CYCLE_LIMIT  = 200000;

  logic        clk, rst_n;
  logic        in_tvalid, in_tready, in_tuser;
  logic [79:0] in_tdata;
  logic        out_tvalid, out_tready;
  logic [15:0] out_tdata;
  int          fail_count, headings_seen, pending_count;
  int          cycle_count, sent_count;
  bit          calm;

  tilt_compensated_heading_unit uut (.*);

  heading_checker checker_i (.*);

  initial begin
    clk = 0;
    forever #4 clk = ~clk;
  end

  initial begin
    cycle_count = 0;
    forever begin
      @(posedge clk);
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
        $display("timeout after %0d cycles", cycle_count);
        $display("testbench: FAIL");
        $finish;
      end
    end
  end

  // output back-pressure in bursts
  initial begin
    int burst;
    out_tready = 0;
    @(negedge clk);
    while (1) begin
      if (!calm && $urandom_range(0, 2) == 0) begin
        burst = $urandom_range(1, 18);
        out_tready = 0;
        repeat (burst) @(negedge clk);
      end else begin
        out_tready = 1;
        repeat ($urandom_range(1, 20)) @(negedge clk);
      end
    end
  end

  function automatic logic [15:0] pick_field();
    case ($urandom_range(0, 5))
      0: return 16'h7fff;
      1: return 16'h8000;
      2: return 16'($signed($urandom_range(0, 400)) - 200);
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [15:0] pick_angle();
    case ($urandom_range(0, 7))
      0: return 16'($urandom);
      1: return 16'(18000 * ($urandom_range(0, 2) - 1));
      2: return 16'(9000 * ($urandom_range(0, 4) - 2));
      default: return 16'($signed($urandom_range(0, 36000)) - 18000);
    endcase
  endfunction

  task automatic send_sample(input logic [15:0] fx, fy, fz, roll, pitch, input logic ok);
    if (!calm && $urandom_range(0, 4) == 0) begin
      in_tvalid <= 0;
      repeat ($urandom_range(1, 18)) @(negedge clk);
    end
    in_tvalid <= 1;
    in_tdata  <= {pitch, roll, fz, fy, fx};
    in_tuser  <= ok;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sent_count++;
    @(negedge clk);
  endtask

  initial begin
    logic [15:0] edge_vals[6];
    edge_vals = '{16'h7fff, 16'h8000, 16'h0000, 16'h0001, 16'hffff, 16'h1000};
    rst_n = 0;
    in_tvalid = 0;
    in_tdata = '0;
    in_tuser = 0;
    calm = 0;
    sent_count = 0;
    repeat (5) @(negedge clk);
    rst_n = 1;

    send_sample(16'h1000, 16'h0000, 16'h0000, 16'd0, 16'd0, 1'b0);
    send_sample(16'h0000, 16'h0000, 16'h0000, 16'd0, 16'd0, 1'b1);
    send_sample(16'h1000, 16'h0000, 16'h0000, 16'd0, 16'd0, 1'b1);
    send_sample(16'h0000, 16'h1000, 16'h0000, 16'd0, 16'd0, 1'b1);
    send_sample(16'hf000, 16'h0000, 16'h0000, 16'd0, 16'd0, 1'b1);
    send_sample(16'h1000, 16'hffff, 16'h0000, 16'd0, 16'd0, 1'b1);
    send_sample(16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'h8000, 1'b1);
    send_sample(16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h7fff, 1'b1);
    send_sample(16'h1234, 16'h0567, 16'hf321, 16'd18000, 16'hb9b0, 1'b1);
    send_sample(16'h1234, 16'h0567, 16'hf321, 16'd9000, 16'hdcd8, 1'b1);
    send_sample(16'h0800, 16'h0300, 16'h0f00, 16'd36000, 16'h8ca0, 1'b1);
    send_sample(16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff, 1'b0);
    for (int i = 0; i < 6; i++)
      send_sample(edge_vals[i], edge_vals[5 - i], edge_vals[(i + 2) % 6],
                  16'($signed(i * 6000) - 18000), 16'(18000 - i * 6000), 1'b1);

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i == RANDOM_ITEMS - 60) calm = 1;
      send_sample(pick_field(), pick_field(), pick_field(), pick_angle(), pick_angle(),
                  $urandom_range(0, 9) != 0);
    end
    in_tvalid <= 0;
    calm = 1;

    while (pending_count != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    $display("sent %0d samples, checked %0d headings incl. invalid, level and tilt cases",
             sent_count, headings_seen);
    if (fail_count == 0) $display("testbench: PASS");
    else $display("testbench: FAIL");
    $finish;
  end
endmodule
